// ===== hdl/tsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types and constants of the three-shear pixel rotate unit: payload
// words, configuration register set, register indexes and datapath widths.
// ----------------------------------------------------------------------------
package tsr_pkg;

  // Field widths
  localparam int LocalWidth  = 16;
  localparam int WorldWidth  = 24;
  localparam int FracBits    = 16;
  localparam int ShearWidth  = FracBits + 1;
  // Both factors enter the multipliers as signed, one bit wider than stored
  localparam int CoefWidth   = ShearWidth + 1;
  localparam int TurnWidth   = 2;

  // Coordinate widths through the shears, sized to keep every value exact
  localparam int X0Width     = LocalWidth + 1;
  localparam int X1Width     = LocalWidth + 2;
  localparam int Y1Width     = LocalWidth + 4;
  localparam int X2Width     = LocalWidth + 4;

  // Configuration port
  localparam int CfgAddrWidth = 5;
  localparam int CfgDataWidth = 32;
  localparam int CfgIdxWidth  = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegQuarterTurns = 3'd0,
    RegShearA       = 3'd1,
    RegShearB       = 3'd2,
    RegCenterX      = 3'd3,
    RegCenterY      = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic        [TurnWidth-1:0]  quarter_turns;
    logic signed [ShearWidth-1:0] shear_a;
    logic        [ShearWidth-1:0] shear_b;
    logic signed [WorldWidth-1:0] center_x;
    logic signed [WorldWidth-1:0] center_y;
  } cfg_t;

  typedef struct packed {
    logic signed [LocalWidth-1:0] local_x;
    logic signed [LocalWidth-1:0] local_y;
    logic signed [WorldWidth-1:0] prior_x;
    logic signed [WorldWidth-1:0] prior_y;
  } in_word_t;

  typedef struct packed {
    logic signed [WorldWidth-1:0] world_x;
    logic signed [WorldWidth-1:0] world_y;
    logic                         changed;
  } out_word_t;

endpackage

// ===== hdl/three_shear_pixel_rotate_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_shear_pixel_rotate_unit
// Rotates one pixel offset about the body center by quarter turns and three
// shears, and reports its new world position and whether it moved.
// ----------------------------------------------------------------------------
// A pixel is taken on every clock edge with start high (busy is always low),
// so a whole body streams through at one pixel per cycle. Each result comes
// out on result_o with done_o high for one cycle, in order, after one
// quarter-turn register, then three shear units of two registers each
// (multiply, then round and add), then the center-add and compare register.
// There is no back-pressure: the receiver must take every word as it
// appears. Change configuration only while no pixel is in flight.
// ----------------------------------------------------------------------------
module three_shear_pixel_rotate_unit
  import tsr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  in_word_t                cmd_i,
  output logic                    done_o,
  output out_word_t               result_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [CfgDataWidth-1:0] pwdata,
  output logic [CfgDataWidth-1:0] prdata,
  output logic                    pready
);

  localparam int SideWidth = 2 * WorldWidth;

  cfg_t                        cfg;
  logic signed [CoefWidth-1:0] coef_a, coef_b;

  logic                        accept;
  logic signed [X0Width-1:0]   lx, ly, x0_d, y0_d, x0_q, y0_q;
  logic        [SideWidth-1:0] side0_q;
  logic                        vld0_q;

  logic                        vld1;
  logic signed [X1Width-1:0]   x1;
  logic signed [X0Width-1:0]   y0_s1;
  logic        [SideWidth-1:0] side1;

  logic                        vld2;
  logic signed [Y1Width-1:0]   y1;
  logic signed [X1Width-1:0]   x1_s2;
  logic        [SideWidth-1:0] side2;

  logic                        vld3;
  logic signed [X2Width-1:0]   x2;
  logic signed [Y1Width-1:0]   y1_s3;
  logic        [SideWidth-1:0] side3;

  out_word_t                   res_d, res_q;
  logic                        done_q;

  tsr_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign coef_a = CoefWidth'(cfg.shear_a);
  assign coef_b = $signed({1'b0, cfg.shear_b});

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Apply the quarter turns; each maps (x, y) to (-y, x)
  assign lx = X0Width'(cmd_i.local_x);
  assign ly = X0Width'(cmd_i.local_y);

  always_comb begin
    case (cfg.quarter_turns)
      2'd1:    begin x0_d = -ly; y0_d = lx;  end
      2'd2:    begin x0_d = -lx; y0_d = -ly; end
      2'd3:    begin x0_d = ly;  y0_d = -lx; end
      default: begin x0_d = lx;  y0_d = ly;  end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x0_q    <= x0_d;
      y0_q    <= y0_d;
      side0_q <= {cmd_i.prior_x, cmd_i.prior_y};
    end
  end

  // First shear: x += round(y * A)
  tsr_shear_stage #(
    .MulWidth  (X0Width),
    .AccWidth  (X0Width),
    .SumWidth  (X1Width),
    .SideWidth (SideWidth)
  ) u_shear_x1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld0_q),
    .mul_i   (y0_q),
    .acc_i   (x0_q),
    .coef_i  (coef_a),
    .side_i  (side0_q),
    .valid_o (vld1),
    .sum_o   (x1),
    .mul_o   (y0_s1),
    .side_o  (side1)
  );

  // Second shear: y += round(x * B)
  tsr_shear_stage #(
    .MulWidth  (X1Width),
    .AccWidth  (X0Width),
    .SumWidth  (Y1Width),
    .SideWidth (SideWidth)
  ) u_shear_y1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld1),
    .mul_i   (x1),
    .acc_i   (y0_s1),
    .coef_i  (coef_b),
    .side_i  (side1),
    .valid_o (vld2),
    .sum_o   (y1),
    .mul_o   (x1_s2),
    .side_o  (side2)
  );

  // Third shear: x += round(y * A)
  tsr_shear_stage #(
    .MulWidth  (Y1Width),
    .AccWidth  (X1Width),
    .SumWidth  (X2Width),
    .SideWidth (SideWidth)
  ) u_shear_x2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld2),
    .mul_i   (y1),
    .acc_i   (x1_s2),
    .coef_i  (coef_a),
    .side_i  (side2),
    .valid_o (vld3),
    .sum_o   (x2),
    .mul_o   (y1_s3),
    .side_o  (side3)
  );

  // Add the body center, wrap to world width, compare with the prior position
  always_comb begin
    res_d.world_x = cfg.center_x + WorldWidth'(x2);
    res_d.world_y = cfg.center_y + WorldWidth'(y1_s3);
    res_d.changed = ({res_d.world_x, res_d.world_y} != side3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld3) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== hdl/tsr_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_cfg_regs
// APB register file holding turn count, shear factors and body center.
// ----------------------------------------------------------------------------
module tsr_cfg_regs
  import tsr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [CfgDataWidth-1:0] pwdata,
  output logic [CfgDataWidth-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg_o
);

  cfg_t                   cfg_d, cfg_q;
  logic                   wr_en;
  logic [CfgIdxWidth-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CfgAddrWidth-1:2];

  // Decode the write; unknown indexes drop the word
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegQuarterTurns: cfg_d.quarter_turns = pwdata[TurnWidth-1:0];
        RegShearA:       cfg_d.shear_a       = $signed(pwdata[ShearWidth-1:0]);
        RegShearB:       cfg_d.shear_b       = pwdata[ShearWidth-1:0];
        RegCenterX:      cfg_d.center_x      = $signed(pwdata[WorldWidth-1:0]);
        RegCenterY:      cfg_d.center_y      = $signed(pwdata[WorldWidth-1:0]);
        default:         cfg_d               = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back the addressed register, zero-extended
  always_comb begin
    unique case (reg_idx)
      RegQuarterTurns: prdata = CfgDataWidth'(cfg_q.quarter_turns);
      RegShearA:       prdata = CfgDataWidth'($unsigned(cfg_q.shear_a));
      RegShearB:       prdata = CfgDataWidth'(cfg_q.shear_b);
      RegCenterX:      prdata = CfgDataWidth'($unsigned(cfg_q.center_x));
      RegCenterY:      prdata = CfgDataWidth'($unsigned(cfg_q.center_y));
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/tsr_shear_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_shear_stage
// One shear: acc + round(mul * coef / 2^FracBits), halves away from zero.
// Two register stages: product, then round and add.
// ----------------------------------------------------------------------------
module tsr_shear_stage
  import tsr_pkg::*;
#(
  parameter int MulWidth  = X0Width,
  parameter int AccWidth  = X0Width,
  parameter int SumWidth  = X1Width,
  parameter int SideWidth = 2 * WorldWidth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [MulWidth-1:0]  mul_i,
  input  logic signed [AccWidth-1:0]  acc_i,
  input  logic signed [CoefWidth-1:0] coef_i,
  input  logic        [SideWidth-1:0] side_i,
  output logic                        valid_o,
  output logic signed [SumWidth-1:0]  sum_o,
  output logic signed [MulWidth-1:0]  mul_o,
  output logic        [SideWidth-1:0] side_o
);

  localparam int ProdWidth = MulWidth + CoefWidth;
  localparam logic signed [ProdWidth-1:0] Half = ProdWidth'(2 ** (FracBits - 1));

  logic                        prod_vld_q;
  logic signed [ProdWidth-1:0] prod_d, prod_q;
  logic signed [AccWidth-1:0]  acc_q;
  logic signed [MulWidth-1:0]  mul_a_q;
  logic        [SideWidth-1:0] side_a_q;

  logic signed [ProdWidth-1:0] rnd;
  logic signed [SumWidth-1:0]  sum_d;
  logic                        sum_vld_q;
  logic signed [SumWidth-1:0]  sum_q;
  logic signed [MulWidth-1:0]  mul_b_q;
  logic        [SideWidth-1:0] side_b_q;

  // Multiply
  assign prod_d = ProdWidth'(mul_i) * ProdWidth'(coef_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      prod_q   <= prod_d;
      acc_q    <= acc_i;
      mul_a_q  <= mul_i;
      side_a_q <= side_i;
    end
  end

  // Round half away from zero: negative products take one less before the shift
  assign rnd   = prod_q + Half - ProdWidth'(prod_q[ProdWidth-1]);
  assign sum_d = SumWidth'(acc_q) + SumWidth'(rnd >>> FracBits);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
    end else begin
      sum_vld_q <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_vld_q) begin
      sum_q    <= sum_d;
      mul_b_q  <= mul_a_q;
      side_b_q <= side_a_q;
    end
  end

  assign valid_o = sum_vld_q;
  assign sum_o   = sum_q;
  assign mul_o   = mul_b_q;
  assign side_o  = side_b_q;

endmodule

// ===== hdl/tsr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_checker
// Port-level checks of the rotate unit: fixed latency and the moved flag.
// ----------------------------------------------------------------------------
module tsr_checker
  import tsr_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input in_word_t  cmd_i,
  input logic      done_o,
  input out_word_t result_o
);

  localparam int Latency = 8;

  // Every accepted word yields a result after the fixed latency
  a_start_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##Latency done_o)
    else $error("accepted word produced no result");

  // No result without a matching accepted word
  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency))
    else $error("result without accepted word");

  // Unmoved pixel reports no change
  a_unmoved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.world_x == $past(cmd_i.prior_x, Latency)
           && result_o.world_y == $past(cmd_i.prior_y, Latency)
    |-> !result_o.changed)
    else $error("changed set on unmoved pixel");

  // Moved pixel reports a change
  a_moved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.world_x != $past(cmd_i.prior_x, Latency)
            || result_o.world_y != $past(cmd_i.prior_y, Latency))
    |-> result_o.changed)
    else $error("changed clear on moved pixel");

endmodule

bind three_shear_pixel_rotate_unit tsr_checker u_tsr_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .cmd_i    (cmd_i),
  .done_o   (done_o),
  .result_o (result_o)
);
